// ===== rtl/sar_pkg.sv =====
// ----------------------------------------------------------------------------
// sar_pkg
// Shared types, constants and codes for the sorted address range table.
// ----------------------------------------------------------------------------
package sar_pkg;

   localparam int MAX_RANGES  = 64;
   localparam int IDX_W       = $clog2(MAX_RANGES);
   localparam int CNT_W       = $clog2(MAX_RANGES + 1);
   localparam int ALIGN_BYTES = 4;
   localparam int ALIGN_W     = $clog2(ALIGN_BYTES);

   typedef logic [IDX_W-1:0] index_type;
   typedef logic [CNT_W-1:0] count_type;

   // Operation codes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_QUERY  = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   // Result status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_OVERLAP = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   // Table read address selects
   localparam logic [2:0] RD_NONE  = 3'd0;
   localparam logic [2:0] RD_MID   = 3'd1;
   localparam logic [2:0] RD_PREV  = 3'd2;
   localparam logic [2:0] RD_NEXT  = 3'd3;
   localparam logic [2:0] RD_SHIFT = 3'd4;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] address;
      logic [31:0] length;
      logic [31:0] fallback;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        contained;
      logic [31:0] hit_base;
      logic [31:0] hit_size;
      logic [31:0] skip;
      logic        entered_mid;
      logic [31:0] next_start;
   } rsp_type;

   typedef struct packed {
      logic [31:0] size;
      logic [31:0] base;
   } entry_type;

   typedef struct packed {
      logic       capture;
      logic [2:0] rd_sel;
      logic       step_search;
      logic       cap_prev;
      logic       clr_prev;
      logic       cap_next;
      logic       clr_next;
      logic       decide;
      logic       write_shift;
      logic       write_new;
      logic       load_rsp;
   } cmd_type;

   typedef struct packed {
      logic req_lookup;
      logic search_open;
      logic pos_nonzero;
      logic pos_below_count;
      logic insert_ok;
      logic shift_more;
   } sts_type;

endpackage

// ===== rtl/sar_ram.sv =====
// ----------------------------------------------------------------------------
// sar_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sar_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/sar_dp.sv =====
// ----------------------------------------------------------------------------
// sar_dp
// Datapath: table memory, binary search bounds, neighbor capture, insert
// checks, entry shifting and the result registers.
// ----------------------------------------------------------------------------
module sar_dp (
   input  logic             clock,
   input  logic             reset,
   input  sar_pkg::req_type req_payload,
   input  sar_pkg::cmd_type cmd,
   output sar_pkg::sts_type sts,
   output sar_pkg::rsp_type rsp_payload
);

   sar_pkg::req_type   req_ff,       req_in;
   sar_pkg::count_type lo_ff,        lo_in;
   sar_pkg::count_type hi_ff,        hi_in;
   sar_pkg::index_type mid_ff,       mid_in;
   sar_pkg::count_type idx_ff,       idx_in;
   sar_pkg::count_type count_ff,     count_in;
   sar_pkg::entry_type prev_ff,      prev_in;
   logic               has_prev_ff,  has_prev_in;
   logic [31:0]        next_base_ff, next_base_in;
   logic               has_next_ff,  has_next_in;
   sar_pkg::rsp_type   res_ff,       res_in;
   sar_pkg::rsp_type   rsp_ff,       rsp_in;

   logic [sar_pkg::CNT_W:0]  mid_sum;
   sar_pkg::count_type       lo_m1;
   sar_pkg::count_type       idx_m1;
   sar_pkg::index_type       rd_addr;
   sar_pkg::index_type       wr_addr;
   logic                     rd_en;
   logic                     wr_en;
   logic [$bits(sar_pkg::entry_type)-1:0] rd_data;
   logic [$bits(sar_pkg::entry_type)-1:0] wr_data;
   sar_pkg::entry_type       rd_entry;

   logic [32:0] addr_end;
   logic [32:0] prev_end;
   logic        invalid;
   logic        overlap;
   logic        full;
   logic [1:0]  ins_status;
   logic        contained;

   // Table memory: {size, base} per entry
   sar_ram #(
      .WIDTH ($bits(sar_pkg::entry_type)),
      .DEPTH (sar_pkg::MAX_RANGES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_entry = rd_data;

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign lo_m1   = lo_ff - sar_pkg::count_type'(1);
   assign idx_m1  = idx_ff - sar_pkg::count_type'(1);

   // Read address select
   always_comb begin
      rd_en   = 1'b1;
      rd_addr = mid_sum[sar_pkg::IDX_W:1];
      case (cmd.rd_sel)
         sar_pkg::RD_MID:   rd_addr = mid_sum[sar_pkg::IDX_W:1];
         sar_pkg::RD_PREV:  rd_addr = lo_m1[sar_pkg::IDX_W-1:0];
         sar_pkg::RD_NEXT:  rd_addr = lo_ff[sar_pkg::IDX_W-1:0];
         sar_pkg::RD_SHIFT: rd_addr = idx_m1[sar_pkg::IDX_W-1:0];
         default:           rd_en   = 1'b0;
      endcase
   end

   // Write: move an entry up one slot, or drop the new range into place
   assign wr_en   = cmd.write_shift | cmd.write_new;
   assign wr_addr = cmd.write_new ? lo_ff[sar_pkg::IDX_W-1:0] : idx_ff[sar_pkg::IDX_W-1:0];
   assign wr_data = cmd.write_new ? {req_ff.length, req_ff.address} : rd_data;

   // Insert checks and query results
   assign addr_end = {1'b0, req_ff.address} + {1'b0, req_ff.length};
   assign prev_end = {1'b0, prev_ff.base} + {1'b0, prev_ff.size};

   assign invalid = (req_ff.length == 32'd0)
                 || (req_ff.address[sar_pkg::ALIGN_W-1:0] != '0)
                 || (req_ff.length[sar_pkg::ALIGN_W-1:0] != '0)
                 || addr_end[32];
   assign overlap = (has_prev_ff && (prev_end > {1'b0, req_ff.address}))
                 || (has_next_ff && (addr_end > {1'b0, next_base_ff}));
   assign full    = count_ff >= sar_pkg::count_type'(sar_pkg::MAX_RANGES);

   always_comb begin
      if (invalid) begin
         ins_status = sar_pkg::ST_INVALID;
      end else if (overlap) begin
         ins_status = sar_pkg::ST_OVERLAP;
      end else if (full) begin
         ins_status = sar_pkg::ST_FULL;
      end else begin
         ins_status = sar_pkg::ST_OK;
      end
   end

   assign contained = has_prev_ff && ({1'b0, req_ff.address} < prev_end);

   always_comb begin
      req_in       = req_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      prev_in      = prev_ff;
      has_prev_in  = has_prev_ff;
      next_base_in = next_base_ff;
      has_next_in  = has_next_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;

      if (cmd.capture) begin
         req_in = req_payload;
         lo_in  = '0;
         hi_in  = count_ff;
         res_in = '0;
         if (req_payload.op == sar_pkg::OP_CLEAR) begin
            count_in = '0;
         end
      end
      if (cmd.rd_sel == sar_pkg::RD_MID) begin
         mid_in = mid_sum[sar_pkg::IDX_W:1];
      end
      if (cmd.step_search) begin
         if (rd_entry.base <= req_ff.address) begin
            lo_in = sar_pkg::count_type'(mid_ff) + sar_pkg::count_type'(1);
         end else begin
            hi_in = sar_pkg::count_type'(mid_ff);
         end
      end
      if (cmd.cap_prev) begin
         prev_in     = rd_entry;
         has_prev_in = 1'b1;
      end
      if (cmd.clr_prev) begin
         has_prev_in = 1'b0;
      end
      if (cmd.cap_next) begin
         next_base_in = rd_entry.base;
         has_next_in  = 1'b1;
      end
      if (cmd.clr_next) begin
         has_next_in = 1'b0;
      end
      if (cmd.decide) begin
         idx_in = count_ff;
         if (req_ff.op == sar_pkg::OP_QUERY) begin
            res_in.status = sar_pkg::ST_OK;
            if (has_next_ff && (next_base_ff < req_ff.fallback)) begin
               res_in.next_start = next_base_ff;
            end else begin
               res_in.next_start = req_ff.fallback;
            end
            if (contained) begin
               res_in.contained   = 1'b1;
               res_in.hit_base    = prev_ff.base;
               res_in.hit_size    = prev_ff.size;
               res_in.skip        = (req_ff.address == prev_ff.base) ? prev_ff.size : 32'd0;
               res_in.entered_mid = (req_ff.address != prev_ff.base);
            end
         end else begin
            res_in.status = ins_status;
         end
      end
      if (cmd.write_shift) begin
         idx_in = idx_m1;
      end
      if (cmd.write_new) begin
         count_in = count_ff + sar_pkg::count_type'(1);
      end
      if (cmd.load_rsp) begin
         rsp_in = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      idx_ff       <= idx_in;
      prev_ff      <= prev_in;
      has_prev_ff  <= has_prev_in;
      next_base_ff <= next_base_in;
      has_next_ff  <= has_next_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
   end

   assign sts.req_lookup      = (req_payload.op == sar_pkg::OP_INSERT)
                             || (req_payload.op == sar_pkg::OP_QUERY);
   assign sts.search_open     = lo_ff < hi_ff;
   assign sts.pos_nonzero     = lo_ff != '0;
   assign sts.pos_below_count = lo_ff < count_ff;
   assign sts.insert_ok       = (req_ff.op == sar_pkg::OP_INSERT) && (ins_status == sar_pkg::ST_OK);
   assign sts.shift_more      = idx_ff > lo_ff;

   assign rsp_payload = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= sar_pkg::count_type'(sar_pkg::MAX_RANGES))
      else $error("range count above table depth");

   a_no_insert_when_full: assert property (@(posedge clock) disable iff (reset)
      cmd.write_new |-> !full)
      else $error("range written into a full table");

   a_search_window: assert property (@(posedge clock) disable iff (reset)
      cmd.step_search |-> (lo_ff < hi_ff))
      else $error("search step with an empty window");

endmodule

// ===== rtl/sar_ctrl.sv =====
// ----------------------------------------------------------------------------
// sar_ctrl
// Controller: sequences search, neighbor reads, decision, shifting and the
// result handoff for one transaction at a time.
// ----------------------------------------------------------------------------
module sar_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  sar_pkg::sts_type sts,
   output sar_pkg::cmd_type cmd
);

   localparam logic [3:0] S_IDLE        = 4'd0;
   localparam logic [3:0] S_SEARCH      = 4'd1;
   localparam logic [3:0] S_SEARCH_WAIT = 4'd2;
   localparam logic [3:0] S_PREV        = 4'd3;
   localparam logic [3:0] S_PREV_WAIT   = 4'd4;
   localparam logic [3:0] S_NEXT        = 4'd5;
   localparam logic [3:0] S_NEXT_WAIT   = 4'd6;
   localparam logic [3:0] S_DECIDE      = 4'd7;
   localparam logic [3:0] S_SHIFT       = 4'd8;
   localparam logic [3:0] S_SHIFT_WAIT  = 4'd9;
   localparam logic [3:0] S_DONE        = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_stall = state_ff != S_IDLE;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               state_in    = sts.req_lookup ? S_SEARCH : S_DONE;
            end
         end
         S_SEARCH: begin
            if (sts.search_open) begin
               cmd.rd_sel = sar_pkg::RD_MID;
               state_in   = S_SEARCH_WAIT;
            end else begin
               state_in = S_PREV;
            end
         end
         S_SEARCH_WAIT: begin
            cmd.step_search = 1'b1;
            state_in        = S_SEARCH;
         end
         S_PREV: begin
            if (sts.pos_nonzero) begin
               cmd.rd_sel = sar_pkg::RD_PREV;
               state_in   = S_PREV_WAIT;
            end else begin
               cmd.clr_prev = 1'b1;
               state_in     = S_NEXT;
            end
         end
         S_PREV_WAIT: begin
            cmd.cap_prev = 1'b1;
            state_in     = S_NEXT;
         end
         S_NEXT: begin
            if (sts.pos_below_count) begin
               cmd.rd_sel = sar_pkg::RD_NEXT;
               state_in   = S_NEXT_WAIT;
            end else begin
               cmd.clr_next = 1'b1;
               state_in     = S_DECIDE;
            end
         end
         S_NEXT_WAIT: begin
            cmd.cap_next = 1'b1;
            state_in     = S_DECIDE;
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = sts.insert_ok ? S_SHIFT : S_DONE;
         end
         S_SHIFT: begin
            if (sts.shift_more) begin
               cmd.rd_sel = sar_pkg::RD_SHIFT;
               state_in   = S_SHIFT_WAIT;
            end else begin
               cmd.write_new = 1'b1;
               state_in      = S_DONE;
            end
         end
         S_SHIFT_WAIT: begin
            cmd.write_shift = 1'b1;
            state_in        = S_SHIFT;
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("result raised outside the handoff state");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != S_IDLE))
      else $error("controller idle right after a transaction was taken");

endmodule

// ===== rtl/sorted_address_range_table.sv =====
// ----------------------------------------------------------------------------
// sorted_address_range_table
// Sorted table of non-overlapping address ranges with checked insert,
// containment query and clear, one transaction at a time.
// ----------------------------------------------------------------------------
// Clear and unused op go from accept straight to the result handoff.
// Insert and query run K binary search steps (K <= ceil(log2(count + 1)),
// 7 for a full 64-entry table), one read at a time on the single read port
// of the table memory, then the neighbor reads and the decision; an accepted
// insert moves the M entries above its slot up. Requests stall meanwhile.
// Reset: range count goes to zero; the table memory is not cleared.
// ----------------------------------------------------------------------------
module sorted_address_range_table (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sar_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sar_pkg::rsp_type rsp_payload
);

   // Command and status between controller and datapath
   sar_pkg::cmd_type cmd;
   sar_pkg::sts_type sts;

   // Controller: walks the search, neighbor reads, decision and shift loop,
   // and owns both handshakes. The request side stalls while a transaction
   // is in flight; the result sits in an output register until taken.
   sar_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath: table memory, search bounds, overlap and alignment checks,
   // and the result fields.
   sar_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== verif/tb_sorted_address_range_table.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_address_range_table
// Self-checking bench for the sorted address range table. A directed table
// covers the insert rejections, boundaries and the unused op code. Random
// phases follow: mixed phases, a fill-to-full phase and a quiet tail. Each
// result is checked against a typed directed row or the in-bench predictor.
// ----------------------------------------------------------------------------
module tb_sorted_address_range_table;
   timeunit 1ns;
   timeprecision 1ps;

   import sar_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int unsigned LONG_HOLD    = 300;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam logic [1:0]  OP_UNUSED    = 2'd3;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type want;
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;

   // Predicted table contents, mirrored at each accepted transaction
   logic [31:0] table_base [MAX_RANGES];
   logic [31:0] table_size [MAX_RANGES];
   int unsigned table_count;

   rsp_type      expected_rsp_q [$];
   stim_row_type directed_rows [$];

   int unsigned error_count;
   int unsigned cycle_count;
   int unsigned sent_count;
   int unsigned sender_gap_pct;
   bit          quiet_tail;
   bit          long_hold_request;

   sorted_address_range_table u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Table predictor
   // ------------------------------------------------------------------------

   // Count stored ranges whose base is at or below addr; this is the slot an
   // insert lands in and the index of the next range for a query.
   function automatic int unsigned bases_at_or_below(logic [31:0] addr);
      int unsigned n;
      n = 0;
      while (n < table_count && table_base[n] <= addr) n++;
      return n;
   endfunction

   // Check an insert in priority order (invalid, overlap, full); commit only
   // when every check passes.
   function automatic logic [1:0] insert_range(logic [31:0] base, logic [31:0] size);
      int unsigned pos;
      int unsigned i;
      if (size == '0 || base[ALIGN_W-1:0] != '0 || size[ALIGN_W-1:0] != '0 ||
          ({1'b0, base} + {1'b0, size}) > 33'h0_FFFF_FFFF) begin
         return ST_INVALID;
      end
      pos = bases_at_or_below(base);
      if (pos > 0 && ({1'b0, table_base[pos-1]} + {1'b0, table_size[pos-1]}) > {1'b0, base}) begin
         return ST_OVERLAP;
      end
      if (pos < table_count && ({1'b0, base} + {1'b0, size}) > {1'b0, table_base[pos]}) begin
         return ST_OVERLAP;
      end
      if (table_count >= MAX_RANGES) begin
         return ST_FULL;
      end
      // Open the slot: move every range above it up by one
      for (i = table_count; i > pos; i--) begin
         table_base[i] = table_base[i-1];
         table_size[i] = table_size[i-1];
      end
      table_base[pos] = base;
      table_size[pos] = size;
      table_count++;
      return ST_OK;
   endfunction

   // Apply one transaction to the predicted table and return its result
   function automatic rsp_type apply_table_op(req_type r);
      rsp_type     res;
      int unsigned pos;
      res = '0;
      case (r.op)
         OP_INSERT: begin
            res.status = insert_range(r.address, r.length);
         end
         OP_QUERY: begin
            pos = bases_at_or_below(r.address);
            res.next_start = r.fallback;
            if (pos < table_count && table_base[pos] < r.fallback) begin
               res.next_start = table_base[pos];
            end
            if (pos > 0 && {1'b0, r.address} <
                ({1'b0, table_base[pos-1]} + {1'b0, table_size[pos-1]})) begin
               res.contained = 1'b1;
               res.hit_base  = table_base[pos-1];
               res.hit_size  = table_size[pos-1];
               if (r.address == table_base[pos-1]) begin
                  res.skip = table_size[pos-1];
               end else begin
                  res.entered_mid = 1'b1;
               end
            end
         end
         OP_CLEAR: begin
            table_count = 0;
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   function automatic rsp_type status_only(logic [1:0] st);
      rsp_type res;
      res = '0;
      res.status = st;
      return res;
   endfunction

   // Query that hits nothing and has no stored base above it
   function automatic rsp_type miss_result(logic [31:0] fb);
      rsp_type res;
      res = '0;
      res.next_start = fb;
      return res;
   endfunction

   function automatic void add_row(logic [1:0] op, logic [31:0] addr, logic [31:0] len,
                                   logic [31:0] fb, bit typed, rsp_type want);
      stim_row_type row;
      row.req.op       = op;
      row.req.address  = addr;
      row.req.length   = len;
      row.req.fallback = fb;
      row.typed        = typed;
      row.want         = want;
      directed_rows.push_back(row);
   endfunction

   // Pick one of three address windows: bottom, middle and the very top,
   // where long ranges run into the end of the address space.
   function automatic logic [31:0] window_base();
      case ($urandom_range(0, 2))
         0:       return 32'h0000_0000;
         1:       return 32'h8000_0000;
         default: return 32'hFFFF_C000;
      endcase
   endfunction

   function automatic logic [31:0] random_fallback(logic [31:0] addr);
      case ($urandom_range(0, 2))
         0:       return 32'hFFFF_FFFF;
         1:       return $urandom;
         default: return addr + $urandom_range(0, 256);
      endcase
   endfunction

   // Mostly well-formed inserts and queries inside small windows so ranges
   // meet, touch and collide; the rest is noise and the occasional clear.
   function automatic req_type random_request();
      req_type     r;
      int unsigned choice;
      int unsigned pick;
      choice = $urandom_range(0, 99);
      r.op       = OP_QUERY;
      r.address  = $urandom;
      r.length   = $urandom;
      r.fallback = $urandom;
      if (choice < 6) begin
         r.op = 2'($urandom_range(0, 3));
      end else if (choice < 8) begin
         r.op = OP_CLEAR;
      end else if (choice < 50) begin
         r.op      = OP_INSERT;
         r.address = window_base() + ($urandom_range(0, 1023) << 4);
         r.length  = $urandom_range(1, 12) * 4;
         if ($urandom_range(0, 19) == 0) begin
            // Break the alignment or the length
            r.address = r.address | $urandom_range(0, 3);
            r.length  = $urandom_range(0, 50);
         end
      end else begin
         if (table_count != 0 && $urandom_range(0, 2) != 0) begin
            pick = $urandom_range(0, table_count - 1);
            r.address = table_base[pick] + $urandom_range(0, 8) - 4;
            if ($urandom_range(0, 1) == 0) begin
               r.address = table_base[pick] + $urandom_range(0, table_size[pick]);
            end
         end else begin
            r.address = window_base() + $urandom_range(0, 16'h3FFF);
         end
         r.fallback = random_fallback(r.address);
      end
      return r;
   endfunction

   // Offer one transaction, hold it until accepted and record its result
   task automatic send_request(input req_type r, input bit typed, input rsp_type want);
      rsp_type predicted;
      if (sent_count % 64 == 0) begin
         sender_gap_pct = $urandom_range(0, 1) ? 25 : 0;
      end
      if (!quiet_tail && $urandom_range(0, 99) < sender_gap_pct) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid   = 1'b1;
      req_payload = r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = apply_table_op(r);
      expected_rsp_q.push_back(typed ? want : predicted);
      sent_count++;
      @(negedge clock);
   endtask

   // Drop valid and hold until every outstanding result has come back
   task automatic wait_for_drain();
      req_valid = 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin : stimulus
      req_type     r;
      int unsigned n;
      int unsigned pick;

      reset             = 1'b1;
      req_valid         = 1'b0;
      req_payload       = '0;
      error_count       = 0;
      sent_count        = 0;
      sender_gap_pct    = 0;
      quiet_tail        = 1'b0;
      long_hold_request = 1'b0;
      table_count       = 0;

      // Empty table, extreme addresses and fallbacks
      add_row(OP_QUERY,  32'h0000_0000, 32'h0,         32'hFFFF_FFFF, 1, miss_result(32'hFFFF_FFFF));
      add_row(OP_QUERY,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1, miss_result(32'h0));
      // Malformed inserts: zero size, odd base, odd size, past the top
      add_row(OP_INSERT, 32'h0000_0100, 32'h0,         32'h0, 1, status_only(ST_INVALID));
      add_row(OP_INSERT, 32'h0000_0102, 32'h4,         32'h0, 1, status_only(ST_INVALID));
      add_row(OP_INSERT, 32'h0000_0100, 32'h6,         32'h0, 1, status_only(ST_INVALID));
      add_row(OP_INSERT, 32'hFFFF_FFFC, 32'h4,         32'h0, 1, status_only(ST_INVALID));
      // Highest range that still fits, then the largest size against it
      add_row(OP_INSERT, 32'hFFFF_FFF8, 32'h4,         32'h0, 1, status_only(ST_OK));
      add_row(OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFC, 32'h0, 1, status_only(ST_OVERLAP));
      add_row(OP_INSERT, 32'h0000_0100, 32'h10,        32'h0, 1, status_only(ST_OK));
      // Equal base, overlap with the next range, overlap with the previous one
      add_row(OP_INSERT, 32'h0000_0100, 32'h4,         32'h0, 1, status_only(ST_OVERLAP));
      add_row(OP_INSERT, 32'h0000_00FC, 32'h8,         32'h0, 1, status_only(ST_OVERLAP));
      add_row(OP_INSERT, 32'h0000_010C, 32'h4,         32'h0, 1, status_only(ST_OVERLAP));
      // Touching ranges above and below are legal
      add_row(OP_INSERT, 32'h0000_0110, 32'h10,        32'h0, 1, status_only(ST_OK));
      add_row(OP_INSERT, 32'h0000_00F0, 32'h10,        32'h0, 1, status_only(ST_OK));
      // Queries: at a base, mid range, last byte, just past, near the top
      add_row(OP_QUERY,  32'h0000_0100, 32'h0,         32'hFFFF_FFFF, 0, '0);
      add_row(OP_QUERY,  32'h0000_0104, 32'h0,         32'h0000_0200, 0, '0);
      add_row(OP_QUERY,  32'h0000_011F, 32'h0,         32'hFFFF_FFFF, 0, '0);
      add_row(OP_QUERY,  32'h0000_0120, 32'h0,         32'h0000_0200, 0, '0);
      add_row(OP_QUERY,  32'h0000_0120, 32'h0,         32'hFFFF_FFFF, 0, '0);
      add_row(OP_QUERY,  32'hFFFF_FFFB, 32'h0,         32'hFFFF_FFFF, 0, '0);
      // Unused op code and clear return an all-zero result
      add_row(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, status_only(ST_OK));
      add_row(OP_CLEAR,  $urandom,      $urandom,      $urandom,      1, status_only(ST_OK));
      add_row(OP_QUERY,  32'h0000_0100, 32'h0,         32'h0000_1234, 1, miss_result(32'h1234));
      // Whole address space as one range, then clear it
      add_row(OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFC, 32'h0, 1, status_only(ST_OK));
      add_row(OP_QUERY,  32'hFFFF_FFFB, 32'h0,         32'h0, 0, '0);
      add_row(OP_CLEAR,  32'h0,         32'h0,         32'h0, 1, status_only(ST_OK));

      repeat (8) @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
      end

      // Mixed traffic; partway through, the receiver holds off for a long
      // stretch while requests keep coming
      for (n = 0; n < 450; n++) begin
         if (n == 200) long_hold_request = 1'b1;
         send_request(random_request(), 0, '0);
      end

      // Let the pipe run dry before the fill phase
      wait_for_drain();

      // Fill the table past capacity with ranges that rarely collide
      r = '0;
      r.op = OP_CLEAR;
      send_request(r, 0, '0);
      for (n = 0; n < 80; n++) begin
         r.op       = OP_INSERT;
         r.address  = window_base() + $urandom_range(0, 255) * 64;
         r.length   = $urandom_range(1, 16) * 4;
         r.fallback = $urandom;
         send_request(r, 0, '0);
      end
      for (n = 0; n < 40; n++) begin
         pick       = $urandom_range(0, table_count - 1);
         r.op       = OP_QUERY;
         r.address  = table_base[pick] + $urandom_range(0, table_size[pick] + 3);
         r.fallback = random_fallback(r.address);
         send_request(r, 0, '0);
      end

      for (n = 0; n < 300; n++) begin
         send_request(random_request(), 0, '0);
      end

      // Back-to-back tail with no idling on either side
      quiet_tail = 1'b1;
      for (n = 0; n < 150; n++) begin
         send_request(random_request(), 0, '0);
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS sorted_address_range_table");
      end else begin
         $display("FAIL sorted_address_range_table");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // Receiver stall: short random bursts, calm stretches, one long hold-off
   // ------------------------------------------------------------------------
   initial begin : result_stall
      int unsigned burst_left;
      int unsigned hold_left;
      int unsigned stall_pct;
      int unsigned cycles;
      burst_left = 0;
      hold_left  = 0;
      stall_pct  = 0;
      cycles     = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         cycles++;
         if (cycles % 128 == 0) stall_pct = $urandom_range(0, 1) ? 20 : 0;
         if (long_hold_request) begin
            hold_left         = LONG_HOLD;
            long_hold_request = 1'b0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall = 1'b1;
         end else if (quiet_tail || reset) begin
            burst_left = 0;
            rsp_stall  = 1'b0;
         end else if (burst_left != 0) begin
            burst_left--;
            rsp_stall = 1'b1;
         end else if ($urandom_range(0, 99) < stall_pct) begin
            burst_left = $urandom_range(0, 3);
            rsp_stall  = 1'b1;
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input rsp_type want, input rsp_type got);
      error_count++;
      if (error_count <= 10) begin
         $display("%0t: %s", $realtime, what);
         $display("   expected st=%0d in=%0b base=%h size=%h skip=%h mid=%0b next=%h",
                  want.status, want.contained, want.hit_base, want.hit_size,
                  want.skip, want.entered_mid, want.next_start);
         $display("   actual   st=%0d in=%0b base=%h size=%h skip=%h mid=%0b next=%h",
                  got.status, got.contained, got.hit_base, got.hit_size,
                  got.skip, got.entered_mid, got.next_start);
      end
   endtask

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp_q.size() == 0) begin
            report_mismatch("result with no transaction outstanding", '0, rsp_payload);
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_payload.status      !== want.status      ||
                rsp_payload.contained   !== want.contained   ||
                rsp_payload.hit_base    !== want.hit_base    ||
                rsp_payload.hit_size    !== want.hit_size    ||
                rsp_payload.skip        !== want.skip        ||
                rsp_payload.entered_mid !== want.entered_mid ||
                rsp_payload.next_start  !== want.next_start) begin
               report_mismatch("result mismatch", want, rsp_payload);
            end
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_rsp_q.size());
         $display("FAIL sorted_address_range_table");
         $finish;
      end
   end

endmodule
